[hw/rtl/ftach_pkg.sv]
package ftach_pkg;

  localparam int COUNTER_BITS_DEF = 32;

  localparam int DVD_BITS = 20;
  localparam int REM_W = DVD_BITS + 1;
  localparam logic [DVD_BITS-1:0] RPM_DIVIDEND = 20'd1000000;

  localparam logic signed [11:0] TEMP_HI = 12'sd1280;
  localparam logic signed [11:0] TEMP_LO = 12'sd480;

  // floor(t16 * 3 / 40) for 480 <= t16 <= 1280 equals (t16 * 1229) >> 14.
  localparam logic [10:0] PCT_RECIP = 11'd1229;
  localparam int PCT_SHIFT = 14;
  // floor(pct * 255 / 100) for pct <= 100 equals (pct * 5223) >> 11.
  localparam logic [12:0] DUTY_RECIP = 13'd5223;
  localparam int DUTY_SHIFT = 11;

  localparam logic [6:0] PCT_MAX = 7'd100;
  localparam logic [6:0] PCT_MIN = 7'd0;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_AUTO_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MANUAL_PCT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 2'd2;

  localparam logic AUTO_MODE_RST = 1'b0;
  localparam logic [6:0] MANUAL_PCT_RST = 7'd50;
  localparam logic [31:0] INTERVAL_RST = 32'd1000000;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

[hw/rtl/fan_tach_rpm_and_pwm_duty_top.sv]
// Fan tachometer and PWM speed control.
// Each input beat is one microsecond tick carrying the sampled tach level and
// the temperature in 1/16 degree C. Every input beat produces exactly one
// output beat with the duty code, the speed percent, the latched RPM and the
// last tach period in ticks.
// A tick without an RPM readout passes from the idle step to the output step,
// then into the output register; the next beat is taken once back in idle.
// A tick that triggers a readout with a nonzero period runs the serial
// divider, one quotient bit per cycle, then passes through the output step to
// the output register before the next beat is let in.
// One tick is in flight at a time; in_stall is high from acceptance until the
// result is loaded into the output register, so the next beat can be taken
// while the previous result still waits on out_stall.
// When the receiver stalls, the output beat holds and the finished tick waits
// in its last step; the block takes no new beat until that result is loaded.
// Configuration writes are always ready and should be issued only when idle.
// Synchronous reset clears the time counters, the period and the RPM, and
// restores manual mode, 50 percent and a readout interval of 1000000 ticks.
module fan_tach_rpm_and_pwm_duty_top #(
  parameter int COUNTER_BITS = ftach_pkg::COUNTER_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_tach_level,
  input  logic signed [11:0]               in_temperature,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [7:0]                       out_duty_code,
  output logic [6:0]                       out_speed_percent,
  output logic [14:0]                      out_rpm,
  output logic [31:0]                      out_pulse_period,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ftach_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                      cfg_data
);

  localparam int W = COUNTER_BITS;
  localparam int RW = (W > 32) ? W : 32;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  logic [1:0]  state_r;
  logic        auto_mode_r;
  logic [6:0]  manual_pct_r;
  logic [31:0] interval_r;

  logic [W-1:0] tick_r;
  logic [W-1:0] last_rise_r;
  logic         tach_prev_r;
  logic [W-1:0] period_r;
  logic [14:0]  rpm_r;
  logic [W-1:0] last_rd_r;

  logic        out_valid_r;
  logic [7:0]  out_duty_r;
  logic [6:0]  out_pct_r;
  logic [14:0] out_rpm_r;
  logic [31:0] out_period_r;

  logic                            accept;
  logic                            rise;
  logic [W-1:0]                    period_nxt;
  logic [W-1:0]                    since_rd;
  logic                            fire;
  logic                            div_start;
  logic                            out_free;
  logic [RW-1:0]                   period_ext;
  logic [6:0]                      pct;
  logic [7:0]                      duty;
  ftach_pkg::div_stat_t            div_stat;
  logic [ftach_pkg::DVD_BITS-1:0]  quot;

  assign in_stall   = (state_r != ST_IDLE);
  assign accept     = in_valid && !in_stall;
  assign rise       = in_tach_level && !tach_prev_r;
  assign period_nxt = rise ? (tick_r - last_rise_r) : period_r;
  assign since_rd   = tick_r - last_rd_r;
  assign fire       = RW'(since_rd) > RW'(interval_r);
  assign div_start  = accept && fire && (period_nxt != '0);
  assign out_free   = !out_valid_r || !out_stall;
  assign period_ext = RW'(period_r);
  assign cfg_ready  = 1'b1;

  ftach_pct u_pct (
    .clk            (clk),
    .load           (accept),
    .auto_mode      (auto_mode_r),
    .manual_percent (manual_pct_r),
    .temperature    (in_temperature),
    .pct            (pct),
    .duty           (duty)
  );

  ftach_div #(
    .DIV_W (W)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .divisor (period_nxt),
    .stat    (div_stat),
    .quot    (quot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      auto_mode_r  <= ftach_pkg::AUTO_MODE_RST;
      manual_pct_r <= ftach_pkg::MANUAL_PCT_RST;
      interval_r   <= ftach_pkg::INTERVAL_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ftach_pkg::CFG_AUTO_MODE:  auto_mode_r  <= cfg_data[0];
        ftach_pkg::CFG_MANUAL_PCT: manual_pct_r <= cfg_data[6:0];
        ftach_pkg::CFG_INTERVAL:   interval_r   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tick_r      <= '0;
      last_rise_r <= '0;
      tach_prev_r <= 1'b0;
      period_r    <= '0;
      rpm_r       <= '0;
      last_rd_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == ST_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            tach_prev_r <= in_tach_level;
            period_r    <= period_nxt;
            tick_r      <= tick_r + W'(1);
            if (rise) begin
              last_rise_r <= tick_r;
            end
            if (fire) begin
              last_rd_r <= tick_r;
              if (period_nxt == '0) begin
                rpm_r <= '0;
              end
            end
            state_r <= div_start ? ST_DIV : ST_OUT;
          end
        end
        ST_DIV: begin
          if (div_stat.done) begin
            rpm_r   <= quot[15:1];
            state_r <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_OUT && out_free) begin
      out_duty_r   <= duty;
      out_pct_r    <= pct;
      out_rpm_r    <= rpm_r;
      out_period_r <= period_ext[31:0];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_duty_code     = out_duty_r;
  assign out_speed_percent = out_pct_r;
  assign out_rpm           = out_rpm_r;
  assign out_pulse_period  = out_period_r;

  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> state_r == ST_DIV)
    else $error("divider finished outside the divide step");

  a_busy_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.busy |-> state_r == ST_DIV)
    else $error("divider running outside the divide step");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r != ST_IDLE)
    else $error("accepted beat did not start processing");

  a_out_from_out_step: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_OUT)
    else $error("output beat raised without a finished tick");

endmodule

[hw/rtl/ftach_div.sv]
module ftach_div #(
  parameter int DIV_W = ftach_pkg::COUNTER_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [DIV_W-1:0]              divisor,
  output ftach_pkg::div_stat_t          stat,
  output logic [ftach_pkg::DVD_BITS-1:0] quot
);

  localparam int DB = ftach_pkg::DVD_BITS;
  localparam int CMP_W = (DIV_W > ftach_pkg::REM_W) ? DIV_W : ftach_pkg::REM_W;
  localparam int CNT_W = $clog2(DB);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DB-1:0]    dvd_r;
  logic [DB-1:0]    rem_r;
  logic [DB-1:0]    quo_r;
  logic [DIV_W-1:0] dsr_r;

  logic [DB:0]      trial;
  logic [CMP_W-1:0] trial_ext;
  logic [CMP_W-1:0] dsr_ext;
  logic [CMP_W-1:0] diff;
  logic             ge;
  logic [DB-1:0]    rem_nxt;

  // One quotient bit per cycle: the partial remainder never exceeds 20 bits.
  assign trial     = {rem_r, dvd_r[DB-1]};
  assign trial_ext = CMP_W'(trial);
  assign dsr_ext   = CMP_W'(dsr_r);
  assign ge        = trial_ext >= dsr_ext;
  assign diff      = trial_ext - dsr_ext;
  assign rem_nxt   = ge ? diff[DB-1:0] : trial[DB-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(DB - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= ftach_pkg::RPM_DIVIDEND;
      rem_r <= '0;
      quo_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[DB-2:0], 1'b0};
      rem_r <= rem_nxt;
      quo_r <= {quo_r[DB-2:0], ge};
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quot      = quo_r;

endmodule

[hw/rtl/ftach_pct.sv]
module ftach_pct (
  input  logic               clk,
  input  logic               load,
  input  logic               auto_mode,
  input  logic [6:0]         manual_percent,
  input  logic signed [11:0] temperature,
  output logic [6:0]         pct,
  output logic [7:0]         duty
);

  logic [6:0]  pct_r;
  logic [6:0]  pct_nxt;
  logic [21:0] temp_prod;
  logic [19:0] duty_prod;

  assign temp_prod = temperature[10:0] * ftach_pkg::PCT_RECIP;

  always_comb begin
    if (auto_mode) begin
      if (temperature > ftach_pkg::TEMP_HI) begin
        pct_nxt = ftach_pkg::PCT_MAX;
      end else if (temperature < ftach_pkg::TEMP_LO) begin
        pct_nxt = ftach_pkg::PCT_MIN;
      end else begin
        pct_nxt = temp_prod[ftach_pkg::PCT_SHIFT +: 7];
      end
    end else if (manual_percent > ftach_pkg::PCT_MAX) begin
      pct_nxt = ftach_pkg::PCT_MAX;
    end else begin
      pct_nxt = manual_percent;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pct_r <= pct_nxt;
    end
  end

  assign duty_prod = pct_r * ftach_pkg::DUTY_RECIP;
  assign pct       = pct_r;
  assign duty      = duty_prod[ftach_pkg::DUTY_SHIFT +: 8];

endmodule
